FILE: rtl/avq_pkg.sv
// Shared types and constants of the argument quoting escaper.
package avq_pkg;

  // Longest argument the splitter accepts; backslash runs saturate at it
  localparam int MAX_ARG_LEN = 32767;
  localparam int RUN_W = 15;
  localparam logic [RUN_W-1:0] RUN_LIMIT =
    RUN_W'((MAX_ARG_LEN < 32767) ? MAX_ARG_LEN : 32767);

  localparam logic [7:0] BYTE_QUOTE     = 8'h22;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_TAB       = 8'h09;

  // Most results one input transaction can cause
  localparam int SLOTS = 4;
  localparam int SLOT_W = 2;
  localparam int USED_W = 3;

  typedef enum logic [1:0] {
    CMD_SCAN     = 2'd0,
    CMD_EMIT     = 2'd1,
    CMD_END      = 2'd2,
    CMD_NEW_LINE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] repeat_res;
    logic        last;
  } result_t;

  // All results of one input transaction, oldest in slot 0
  typedef struct packed {
    result_t [SLOTS-1:0] slot;
    logic [USED_W-1:0]   used;
  } bundle_t;

  // Queue head as seen by the back end
  typedef struct packed {
    bundle_t data;
    logic    valid;
  } head_t;

endpackage

FILE: rtl/avq_front.sv
// Front end: takes input transactions, keeps argument state, builds result bundles.
module avq_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       command,
  input  logic [7:0]       in_byte,
  output avq_pkg::bundle_t bundle,
  output logic             bundle_push
);

  logic                      has_blank, has_blank_next;
  logic                      arg_nonempty, arg_nonempty_next;
  logic                      emit_started, emit_started_next;
  logic                      later_argument, later_argument_next;
  logic [avq_pkg::RUN_W-1:0] backslash_run, backslash_run_next;

  // Append one result to a bundle
  function automatic avq_pkg::bundle_t put(input avq_pkg::bundle_t b,
                                           input logic [7:0] value,
                                           input logic [15:0] count,
                                           input logic last);
    b.slot[b.used[avq_pkg::SLOT_W-1:0]].out_byte   = value;
    b.slot[b.used[avq_pkg::SLOT_W-1:0]].repeat_res = count;
    b.slot[b.used[avq_pkg::SLOT_W-1:0]].last       = last;
    b.used = b.used + avq_pkg::USED_W'(1);
    return b;
  endfunction

  // Decode the command and work out results and next state
  always_comb begin
    has_blank_next      = has_blank;
    arg_nonempty_next   = arg_nonempty;
    emit_started_next   = emit_started;
    later_argument_next = later_argument;
    backslash_run_next  = backslash_run;
    bundle              = '0;
    unique case (avq_pkg::cmd_t'(command))
      avq_pkg::CMD_NEW_LINE: begin
        has_blank_next      = 1'b0;
        arg_nonempty_next   = 1'b0;
        emit_started_next   = 1'b0;
        later_argument_next = 1'b0;
        backslash_run_next  = '0;
      end
      avq_pkg::CMD_SCAN: begin
        if (!emit_started) begin
          arg_nonempty_next = 1'b1;
          if (in_byte == avq_pkg::BYTE_SPACE || in_byte == avq_pkg::BYTE_TAB) begin
            has_blank_next = 1'b1;
          end
        end
      end
      avq_pkg::CMD_EMIT: begin
        // first byte: separator and opening quote
        if (!emit_started) begin
          if (later_argument) begin
            bundle = put(bundle, avq_pkg::BYTE_SPACE, 16'd1, 1'b0);
          end
          if (has_blank) begin
            bundle = put(bundle, avq_pkg::BYTE_QUOTE, 16'd1, 1'b0);
          end
          emit_started_next   = 1'b1;
          later_argument_next = 1'b1;
        end
        if (in_byte == avq_pkg::BYTE_BACKSLASH) begin
          if (backslash_run < avq_pkg::RUN_LIMIT) begin
            backslash_run_next = backslash_run + avq_pkg::RUN_W'(1);
          end
          bundle = put(bundle, avq_pkg::BYTE_BACKSLASH, 16'd1, 1'b0);
        end else if (in_byte == avq_pkg::BYTE_QUOTE) begin
          // double the pending run and escape the quote
          bundle = put(bundle, avq_pkg::BYTE_BACKSLASH,
                       {1'b0, backslash_run} + 16'd1, 1'b0);
          bundle = put(bundle, avq_pkg::BYTE_QUOTE, 16'd1, 1'b0);
          backslash_run_next = '0;
        end else begin
          backslash_run_next = '0;
          bundle = put(bundle, in_byte, 16'd1, 1'b0);
        end
      end
      avq_pkg::CMD_END: begin
        if (!emit_started) begin
          if (later_argument) begin
            bundle = put(bundle, avq_pkg::BYTE_SPACE, 16'd1, 1'b0);
          end
          if (!arg_nonempty || has_blank) begin
            bundle = put(bundle, avq_pkg::BYTE_QUOTE, 16'd2, 1'b1);
          end else begin
            bundle = put(bundle, 8'd0, 16'd0, 1'b1);
          end
        end else if (has_blank) begin
          // trailing run doubled ahead of the closing quote
          if (backslash_run != '0) begin
            bundle = put(bundle, avq_pkg::BYTE_BACKSLASH, {1'b0, backslash_run}, 1'b0);
          end
          bundle = put(bundle, avq_pkg::BYTE_QUOTE, 16'd1, 1'b1);
        end else begin
          bundle = put(bundle, 8'd0, 16'd0, 1'b1);
        end
        has_blank_next      = 1'b0;
        arg_nonempty_next   = 1'b0;
        emit_started_next   = 1'b0;
        later_argument_next = 1'b1;
        backslash_run_next  = '0;
      end
      default: begin
      end
    endcase
  end

  assign bundle_push = accept && (bundle.used != '0);

  // Argument state
  always_ff @(posedge clk) begin
    if (rst) begin
      has_blank      <= 1'b0;
      arg_nonempty   <= 1'b0;
      emit_started   <= 1'b0;
      later_argument <= 1'b0;
      backslash_run  <= '0;
    end else if (accept) begin
      has_blank      <= has_blank_next;
      arg_nonempty   <= arg_nonempty_next;
      emit_started   <= emit_started_next;
      later_argument <= later_argument_next;
      backslash_run  <= backslash_run_next;
    end
  end

endmodule

FILE: rtl/avq_queue.sv
// Bundle queue between the front end and the back end.
module avq_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  avq_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output avq_pkg::head_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  avq_pkg::bundle_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full       = (fill == FULL_CNT);
  assign head.valid = (fill != '0);
  assign head.data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && head.valid) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push && !full, pop && head.valid})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/avq_back.sv
// Back end: hands out the results of the head bundle one transaction at a time.
module avq_back (
  input  logic           clk,
  input  logic           rst,
  input  avq_pkg::head_t head,
  output logic           head_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic [15:0]    repeat_res,
  output logic           last
);

  logic [avq_pkg::SLOT_W-1:0] idx;
  logic                       take;
  logic                       head_done;
  avq_pkg::result_t           cur;

  assign empty      = !head.valid;
  assign take       = pop && head.valid;
  assign cur        = head.data.slot[idx];
  assign head_done  = ({1'b0, idx} == head.data.used - avq_pkg::USED_W'(1));
  assign head_pop   = take && head_done;
  assign out_byte   = cur.out_byte;
  assign repeat_res = cur.repeat_res;
  assign last       = cur.last;

  // Slot index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= head_done ? '0 : idx + avq_pkg::SLOT_W'(1);
    end
  end

endmodule

FILE: rtl/argv_quoting_escaper.sv
// Top level of the argument quoting escaper.
//
// Usage: each argument is sent twice on the input queue port: once as scan
// transactions (command 0) to note blanks and emptiness, then as emit
// transactions (command 1), closed by an end transaction (command 2).
// Command 3 starts a new command line. An input transaction is taken when
// push is high and full is low.
// Results leave as run-length transactions (out_byte, repeat_res, last) on a
// queue port: the head result is valid while empty is low and is taken when
// pop is high. A zero repeat_res marks an empty result.
// A taken transaction's results are registered into the bundle queue behind
// any waiting bundles. Throughput: one input transaction per cycle while full
// is low, one result per cycle while pop is high; a bundle of several results
// (up to four) holds the back end until all are taken, so the QUEUE_DEPTH
// bundles fill, raising full. Scan and new-line commands cause no results.
// Reset clears all argument state and empties the queue. While pop stays low
// the queue fills, full rises and input stops; nothing is dropped.
module argv_quoting_escaper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [15:0] repeat_res,
  output logic        last
);

  logic             accept;
  avq_pkg::bundle_t bundle;
  logic             bundle_push;
  avq_pkg::head_t   head;
  logic             head_pop;

  assign accept = push && !full;

  // Classify and build result bundles
  avq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .in_byte     (in_byte),
    .bundle      (bundle),
    .bundle_push (bundle_push)
  );

  // Decoupling queue
  avq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (bundle_push),
    .push_data (bundle),
    .full      (full),
    .pop       (head_pop),
    .head      (head)
  );

  // Serialize results
  avq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .repeat_res (repeat_res),
    .last       (last)
  );

  // An empty marker is always the closing result with a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (!empty && repeat_res == 16'd0) |-> (out_byte == 8'd0 && last))
    else $error("empty marker malformed");

  // A doubled quote only closes an argument
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte == avq_pkg::BYTE_QUOTE && repeat_res == 16'd2) |-> last)
    else $error("quote pair not marked last");

  // An end transaction always leaves a result waiting next cycle
  assert property (@(posedge clk) disable iff (rst)
    (push && !full && command == avq_pkg::CMD_END) |=> !empty)
    else $error("end of argument produced no result");

  // A backslash run result never carries the last flag
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte == avq_pkg::BYTE_BACKSLASH && repeat_res != 16'd0) |-> !last)
    else $error("backslash run marked last");

endmodule
